// File: rtl/stc_pkg.sv
package stc_pkg;

    localparam int VALUE_WIDTH_DEFAULT   = 32;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int STOP_COUNT = 5;
    localparam int COLOR_W    = 8;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MINIMUM = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MAXIMUM = 2'd1;

    localparam logic [COLOR_W-1:0] ALPHA_VALID = 8'd166;

    // index division: two restoring steps give the stop index 0..3
    localparam int IDX_STEPS = 2;
    localparam int IDX_QW    = 2;

    // channel division: nine restoring steps, three lanes (red, green, blue)
    localparam int CH_LANES      = 3;
    localparam int CH_STEPS      = 9;
    localparam int CH_QW         = 9;
    localparam int CH_EXTRA_BITS = 10;

    localparam logic [COLOR_W-1:0] STOP_RGB [0:STOP_COUNT-1][0:CH_LANES-1] = '{
        '{8'd68,  8'd1,   8'd84},
        '{8'd59,  8'd82,  8'd139},
        '{8'd33,  8'd145, 8'd140},
        '{8'd94,  8'd201, 8'd98},
        '{8'd253, 8'd231, 8'd37}
    };

    function automatic logic [COLOR_W-1:0] stop_level(logic [2:0] idx, logic [1:0] ch);
        logic [COLOR_W-1:0] level;
        level = '0;
        if ((int'(idx) < STOP_COUNT) && (int'(ch) < CH_LANES))
        begin
            level = STOP_RGB[idx][ch];
        end
        return level;
    endfunction

endpackage

// File: rtl/stc_if.sv
interface stc_cell_if #(parameter int VALUE_WIDTH = stc_pkg::VALUE_WIDTH_DEFAULT);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] cell_value;
    logic                   cell_valid;

    modport source (output valid, output cell_value, output cell_valid, input ready);
    modport sink   (input valid, input cell_value, input cell_valid, output ready);
endinterface

interface stc_rgba_if;
    logic                        valid;
    logic                        ready;
    logic [stc_pkg::COLOR_W-1:0] red;
    logic [stc_pkg::COLOR_W-1:0] green;
    logic [stc_pkg::COLOR_W-1:0] blue;
    logic [stc_pkg::COLOR_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

interface stc_cfg_if #(parameter int VALUE_WIDTH = stc_pkg::VALUE_WIDTH_DEFAULT);
    logic                            valid;
    logic                            ready;
    logic [stc_pkg::CFG_INDEX_W-1:0] index;
    logic [VALUE_WIDTH-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/scalar_to_colormap_rgba.sv
// scalar_to_colormap_rgba
//
// Maps a signed fixed point cell value to RGBA on a five-stop ramp between
// the configured range_minimum and range_maximum.
//
// Channels: sample (cell_value, cell_valid) in, color (red, green, blue,
// alpha) out, both valid/ready; a transfer happens when both are high.
// cfg writes register 0 (range_minimum) or 1 (range_maximum); other
// indexes are dropped. cfg.ready is always high; write only while idle.
//
// Throughput is one cell per cycle while color is not stalled. The pipeline
// from sample transfer to color valid is one front stage, two index division
// cells, one blend stage and nine channel division cells, one restoring step
// each. The nine-step channel division sets the depth.
//
// Reset empties the pipeline and loads range 0 .. 1.0. When color is
// stalled the cells hold; sample stays ready while any cell is empty.
module scalar_to_colormap_rgba #(
    parameter int VALUE_WIDTH   = stc_pkg::VALUE_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = stc_pkg::FRACTION_BITS_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    stc_cell_if.sink   sample,
    stc_rgba_if.source color,
    stc_cfg_if.sink    cfg
);

    localparam int W         = VALUE_WIDTH;
    localparam int IDX_STEPS = stc_pkg::IDX_STEPS;
    localparam int CH_STEPS  = stc_pkg::CH_STEPS;
    localparam int LANES     = stc_pkg::CH_LANES;
    localparam int IDX_RW    = W + 2;
    localparam int IDX_QW    = stc_pkg::IDX_QW;
    localparam int CH_RW     = W + stc_pkg::CH_EXTRA_BITS;
    localparam int CH_QW     = stc_pkg::CH_QW;
    localparam int CW        = stc_pkg::COLOR_W;
    localparam int S_BLEND   = 1 + IDX_STEPS;
    localparam int NSTG      = 2 + IDX_STEPS + CH_STEPS;

    logic [W-1:0] range_minimum_reg, range_minimum_next;
    logic [W-1:0] range_maximum_reg, range_maximum_next;

    logic [NSTG-1:0] stg_vld;
    logic [NSTG-1:0] stg_rdy;

    logic [0:0][IDX_RW-1:0] idx_r    [0:IDX_STEPS];
    logic [0:0][IDX_QW-1:0] idx_q    [0:IDX_STEPS];
    logic [W-1:0]           idx_d    [0:IDX_STEPS];
    logic [0:0]             idx_side [0:IDX_STEPS];

    logic [LANES-1:0][CH_RW-1:0] ch_r    [0:CH_STEPS];
    logic [LANES-1:0][CH_QW-1:0] ch_q    [0:CH_STEPS];
    logic [W:0]                  ch_d    [0:CH_STEPS];
    logic [CW-1:0]               ch_side [0:CH_STEPS];

    assign cfg.ready = 1'b1;

    always_comb
    begin
        range_minimum_next = range_minimum_reg;
        range_maximum_next = range_maximum_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                stc_pkg::REG_RANGE_MINIMUM: range_minimum_next = cfg.data;
                stc_pkg::REG_RANGE_MAXIMUM: range_maximum_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_minimum_reg <= '0;
            range_maximum_reg <= W'(1) << FRACTION_BITS;
        end
        else
        begin
            range_minimum_reg <= range_minimum_next;
            range_maximum_reg <= range_maximum_next;
        end
    end

    // a cell loads when it is empty or its successor loads
    assign stg_rdy[NSTG-1] = !stg_vld[NSTG-1] || color.ready;
    genvar s;
    generate
        for (s = 0; s < NSTG - 1; s++)
        begin : g_rdy
            assign stg_rdy[s] = !stg_vld[s] || stg_rdy[s+1];
        end
    endgenerate

    assign sample.ready = stg_rdy[0];
    assign idx_q[0]     = '0;

    stc_front #(
        .VALUE_WIDTH (W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (stg_rdy[0]),
        .in_vld         (sample.valid),
        .cell_value     (sample.cell_value),
        .cell_valid     (sample.cell_valid),
        .range_minimum  (range_minimum_reg),
        .range_maximum  (range_maximum_reg),
        .out_vld        (stg_vld[0]),
        .out_valid_cell (idx_side[0][0]),
        .out_den        (idx_d[0]),
        .out_scaled     (idx_r[0][0])
    );

    genvar i;
    generate
        for (i = 0; i < IDX_STEPS; i++)
        begin : g_idx
            stc_div_cell #(
                .LANES (1),
                .RW    (IDX_RW),
                .DW    (W),
                .QW    (IDX_QW),
                .SHIFT (IDX_STEPS - 1 - i),
                .SW    (1)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (stg_rdy[1+i]),
                .in_vld   (stg_vld[i]),
                .in_r     (idx_r[i]),
                .in_q     (idx_q[i]),
                .in_d     (idx_d[i]),
                .in_side  (idx_side[i]),
                .out_vld  (stg_vld[1+i]),
                .out_r    (idx_r[i+1]),
                .out_q    (idx_q[i+1]),
                .out_d    (idx_d[i+1]),
                .out_side (idx_side[i+1])
            );
        end
    endgenerate

    stc_blend #(
        .VALUE_WIDTH (W)
    ) u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (stg_rdy[S_BLEND]),
        .in_vld     (stg_vld[S_BLEND-1]),
        .lower      (idx_q[IDX_STEPS][0]),
        .rem        (idx_r[IDX_STEPS][0][W-1:0]),
        .den        (idx_d[IDX_STEPS]),
        .valid_cell (idx_side[IDX_STEPS][0]),
        .out_vld    (stg_vld[S_BLEND]),
        .out_y      (ch_r[0]),
        .out_q      (ch_q[0]),
        .out_d      (ch_d[0]),
        .out_alpha  (ch_side[0])
    );

    generate
        for (i = 0; i < CH_STEPS; i++)
        begin : g_ch
            stc_div_cell #(
                .LANES (LANES),
                .RW    (CH_RW),
                .DW    (W + 1),
                .QW    (CH_QW),
                .SHIFT (CH_STEPS - 1 - i),
                .SW    (CW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (stg_rdy[S_BLEND+1+i]),
                .in_vld   (stg_vld[S_BLEND+i]),
                .in_r     (ch_r[i]),
                .in_q     (ch_q[i]),
                .in_d     (ch_d[i]),
                .in_side  (ch_side[i]),
                .out_vld  (stg_vld[S_BLEND+1+i]),
                .out_r    (ch_r[i+1]),
                .out_q    (ch_q[i+1]),
                .out_d    (ch_d[i+1]),
                .out_side (ch_side[i+1])
            );
        end
    endgenerate

    assign color.valid = stg_vld[NSTG-1];
    assign color.red   = ch_q[CH_STEPS][0][CW-1:0];
    assign color.green = ch_q[CH_STEPS][1][CW-1:0];
    assign color.blue  = ch_q[CH_STEPS][2][CW-1:0];
    assign color.alpha = ch_side[CH_STEPS];

endmodule

// File: rtl/stc_front.sv
module stc_front #(
    parameter int VALUE_WIDTH = stc_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [VALUE_WIDTH-1:0] cell_value,
    input  logic                   cell_valid,
    input  logic [VALUE_WIDTH-1:0] range_minimum,
    input  logic [VALUE_WIDTH-1:0] range_maximum,
    output logic                   out_vld,
    output logic                   out_valid_cell,
    output logic [VALUE_WIDTH-1:0] out_den,
    output logic [VALUE_WIDTH+1:0] out_scaled
);

    localparam int W = VALUE_WIDTH;

    logic signed [W:0] v_ext;
    logic signed [W:0] lo_ext;
    logic signed [W:0] hi_ext;
    logic signed [W:0] span;
    logic signed [W:0] offset;
    logic              range_empty;
    logic              at_or_below;
    logic              at_or_above;

    logic           vld_reg;
    logic           valid_cell_reg, valid_cell_next;
    logic [W-1:0]   den_reg, den_next;
    logic [W+1:0]   scaled_reg, scaled_next;

    assign v_ext  = $signed({cell_value[W-1], cell_value});
    assign lo_ext = $signed({range_minimum[W-1], range_minimum});
    assign hi_ext = $signed({range_maximum[W-1], range_maximum});

    assign span   = hi_ext - lo_ext;
    assign offset = v_ext - lo_ext;

    assign range_empty = (hi_ext <= lo_ext);
    assign at_or_below = (v_ext <= lo_ext);
    assign at_or_above = (v_ext >= hi_ext);

    // end points map to den 1: scaled 0 gives stop 0, 2 gives stop 2,
    // 4 gives index 3 with remainder equal to den, i.e. stop 4 exactly
    always_comb
    begin
        valid_cell_next = cell_valid;
        den_next        = W'(1);
        scaled_next     = '0;
        if (!cell_valid || (!range_empty && at_or_below))
        begin
            scaled_next = '0;
        end
        else if (range_empty)
        begin
            scaled_next = (W+2)'(2);
        end
        else if (at_or_above)
        begin
            scaled_next = (W+2)'(4);
        end
        else
        begin
            den_next    = span[W-1:0];
            scaled_next = {offset[W-1:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            valid_cell_reg <= valid_cell_next;
            den_reg        <= den_next;
            scaled_reg     <= scaled_next;
        end
    end

    assign out_vld        = vld_reg;
    assign out_valid_cell = valid_cell_reg;
    assign out_den        = den_reg;
    assign out_scaled     = scaled_reg;

endmodule

// File: rtl/stc_div_cell.sv
module stc_div_cell #(
    parameter int LANES = 1,
    parameter int RW    = 8,
    parameter int DW    = 8,
    parameter int QW    = 2,
    parameter int SHIFT = 0,
    parameter int SW    = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [LANES-1:0][RW-1:0]    in_r,
    input  logic [LANES-1:0][QW-1:0]    in_q,
    input  logic [DW-1:0]               in_d,
    input  logic [SW-1:0]               in_side,
    output logic                        out_vld,
    output logic [LANES-1:0][RW-1:0]    out_r,
    output logic [LANES-1:0][QW-1:0]    out_q,
    output logic [DW-1:0]               out_d,
    output logic [SW-1:0]               out_side
);

    localparam logic [QW-1:0] Q_STEP = QW'(1) << SHIFT;

    logic [RW-1:0] d_shift;

    logic                     vld_reg;
    logic [LANES-1:0][RW-1:0] r_reg, r_next;
    logic [LANES-1:0][QW-1:0] q_reg, q_next;
    logic [DW-1:0]            d_reg;
    logic [SW-1:0]            side_reg;

    assign d_shift = RW'(in_d) << SHIFT;

    // one restoring step per lane against the shared divisor
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (in_r[l] >= d_shift)
            begin
                r_next[l] = in_r[l] - d_shift;
                q_next[l] = in_q[l] + Q_STEP;
            end
            else
            begin
                r_next[l] = in_r[l];
                q_next[l] = in_q[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= r_next;
            q_reg    <= q_next;
            d_reg    <= in_d;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_r    = r_reg;
    assign out_q    = q_reg;
    assign out_d    = d_reg;
    assign out_side = side_reg;

endmodule

// File: rtl/stc_blend.sv
module stc_blend #(
    parameter int VALUE_WIDTH = stc_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [stc_pkg::IDX_QW-1:0] lower,
    input  logic [VALUE_WIDTH-1:0]     rem,
    input  logic [VALUE_WIDTH-1:0]     den,
    input  logic                       valid_cell,
    output logic                       out_vld,
    output logic [stc_pkg::CH_LANES-1:0][VALUE_WIDTH+stc_pkg::CH_EXTRA_BITS-1:0] out_y,
    output logic [stc_pkg::CH_LANES-1:0][stc_pkg::CH_QW-1:0] out_q,
    output logic [VALUE_WIDTH:0]       out_d,
    output logic [stc_pkg::COLOR_W-1:0] out_alpha
);

    localparam int W     = VALUE_WIDTH;
    localparam int LANES = stc_pkg::CH_LANES;
    localparam int RW    = W + stc_pkg::CH_EXTRA_BITS;
    localparam int QW    = stc_pkg::CH_QW;
    localparam int YW    = W + 12;
    localparam int CW    = stc_pkg::COLOR_W;

    logic [2:0]                 lo_idx;
    logic [2:0]                 hi_idx;
    logic [CW-1:0]              lo_lvl [LANES];
    logic [CW-1:0]              hi_lvl [LANES];
    logic signed [CW:0]         diff [LANES];
    logic signed [W+CW+1:0]     prod [LANES];
    logic signed [YW-1:0]       y_full [LANES];
    logic signed [YW-1:0]       den_ext;

    logic                       vld_reg;
    logic [LANES-1:0][RW-1:0]   y_reg, y_next;
    logic [LANES-1:0][QW-1:0]   q_reg, q_next;
    logic [W:0]                 d_reg;
    logic [CW-1:0]              alpha_reg, alpha_next;

    assign lo_idx  = {1'b0, lower};
    assign hi_idx  = lo_idx + 3'd1;
    assign den_ext = $signed(YW'(den));

    // numerator 2*(hi-lo)*rem + 513*den over divisor 2*den; the offset of
    // 256 keeps it positive and drops out of the low eight bits
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lo_lvl[l] = valid_cell ? stc_pkg::stop_level(lo_idx, 2'(l)) : '0;
            hi_lvl[l] = valid_cell ? stc_pkg::stop_level(hi_idx, 2'(l)) : '0;
            diff[l]   = $signed({1'b0, hi_lvl[l]}) - $signed({1'b0, lo_lvl[l]});
            prod[l]   = diff[l] * $signed({1'b0, rem});
            y_full[l] = (YW'(prod[l]) <<< 1) + (den_ext <<< 9) + den_ext;
            y_next[l] = y_full[l][RW-1:0];
            q_next[l] = QW'(lo_lvl[l]);
        end
        alpha_next = valid_cell ? stc_pkg::ALPHA_VALID : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg     <= y_next;
            q_reg     <= q_next;
            d_reg     <= {den, 1'b0};
            alpha_reg <= alpha_next;
        end
    end

    assign out_vld   = vld_reg;
    assign out_y     = y_reg;
    assign out_q     = q_reg;
    assign out_d     = d_reg;
    assign out_alpha = alpha_reg;

endmodule

// File: rtl/stc_checker.sv
module stc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [stc_pkg::COLOR_W-1:0] red,
    input logic [stc_pkg::COLOR_W-1:0] green,
    input logic [stc_pkg::COLOR_W-1:0] blue,
    input logic [stc_pkg::COLOR_W-1:0] alpha
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue) && $stable(alpha))
        else $error("stalled result changed");

    // a no-data cell is all zeros, any other has the fixed alpha
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (alpha == stc_pkg::ALPHA_VALID)
            || (alpha == '0 && red == '0 && green == '0 && blue == '0))
        else $error("bad alpha or colour for no-data cell");

    // input back-pressure only when the full pipeline is blocked at the output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input not ready while output ready");

    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready || !in_valid)
        else $error("input refused with empty output");

endmodule

bind scalar_to_colormap_rgba stc_checker u_stc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (color.valid),
    .out_ready (color.ready),
    .red       (color.red),
    .green     (color.green),
    .blue      (color.blue),
    .alpha     (color.alpha)
);
